[sv/slndr_pkg.sv]
// ----------------------------------------------------------------------------
// Sorted line list package
// Word types, status and action codes and defaults shared by the sorted
// line list with near-duplicate rejection.
// ----------------------------------------------------------------------------
package slndr_pkg;

  // Field widths fixed by the word formats.
  localparam int unsigned KEY_W  = 48;
  localparam int unsigned PAY_W  = 32;
  localparam int unsigned THR_W  = 32;
  localparam int unsigned RIDX_W = 6;
  localparam int unsigned CNTO_W = 7;
  localparam int unsigned STAT_W = 3;
  localparam int unsigned ACT_W  = 2;

  // Default list depth.
  localparam int unsigned CAPACITY_DEF = 64;

  // Threshold after reset: 0.005 in Q8.24.
  localparam logic [THR_W-1:0] THR_RESET = 32'd83886;

  // Action codes.
  localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
  localparam logic [ACT_W-1:0] ACT_READ   = 2'd1;
  localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd2;

  // Status codes.
  localparam logic [STAT_W-1:0] ST_INSERTED  = 3'd0;
  localparam logic [STAT_W-1:0] ST_NEAR_DUP  = 3'd1;
  localparam logic [STAT_W-1:0] ST_FULL      = 3'd2;
  localparam logic [STAT_W-1:0] ST_READ_OK   = 3'd3;
  localparam logic [STAT_W-1:0] ST_BAD_INDEX = 3'd4;
  localparam logic [STAT_W-1:0] ST_CLEARED   = 3'd5;

  // Input word.
  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [KEY_W-1:0]  line_key;
    logic [PAY_W-1:0]  line_payload;
    logic [RIDX_W-1:0] read_index;
  } in_word_t;

  // Result word.
  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [KEY_W-1:0]  entry_key_out;
    logic [PAY_W-1:0]  entry_payload_out;
    logic [CNTO_W-1:0] entry_count_out;
  } out_word_t;

  // Broadcast control from the sequencer to every cell.
  typedef struct packed {
    logic              cmp_en;
    logic              shift_en;
    logic [KEY_W-1:0]  key;
    logic [PAY_W-1:0]  payload;
    logic [THR_W-1:0]  thr;
    logic [RIDX_W-1:0] read_index;
  } cell_ctrl_t;

endpackage

[sv/slndr_cell.sv]
// ----------------------------------------------------------------------------
// Sorted line list cell
// Holds one record of the sorted list, compares it against the broadcast
// key and shifts in from its left neighbor on an insert.
// ----------------------------------------------------------------------------
module slndr_cell #(
  parameter int unsigned CELL_IDX = 0,
  parameter int unsigned CNT_W    = 7
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  slndr_pkg::cell_ctrl_t          ctrl_i,
  input  logic [CNT_W-1:0]               count_i,
  input  logic [slndr_pkg::KEY_W-1:0]    left_key_i,
  input  logic [slndr_pkg::PAY_W-1:0]    left_payload_i,
  input  logic                           left_ins_i,
  output logic [slndr_pkg::KEY_W-1:0]    key_o,
  output logic [slndr_pkg::PAY_W-1:0]    payload_o,
  output logic                           ins_o,
  output logic                           near_o,
  output logic                           hit_o
);

  logic [slndr_pkg::KEY_W-1:0] key_q;
  logic [slndr_pkg::PAY_W-1:0] payload_q;
  logic                        ins_q, near_q, hit_q;
  logic                        valid;
  logic [slndr_pkg::KEY_W-1:0] key_gap;
  logic                        ins_d, near_d, hit_d;

  // The cell holds a record when its position is below the fill count.
  assign valid = (32'(count_i) > 32'(CELL_IDX));

  // Exact distance between the broadcast key and the stored key.
  always_comb begin
    if (ctrl_i.key >= key_q) begin
      key_gap = ctrl_i.key - key_q;
    end else begin
      key_gap = key_q - ctrl_i.key;
    end
    near_d = valid &&
             (key_gap < {{(slndr_pkg::KEY_W-slndr_pkg::THR_W){1'b0}}, ctrl_i.thr});
    // An empty cell counts as lying after the new key.
    ins_d  = !valid || (key_q > ctrl_i.key);
    hit_d  = (32'(ctrl_i.read_index) == 32'(CELL_IDX));
  end

  // Compare flags are taken in the compare cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ins_q  <= 1'b0;
      near_q <= 1'b0;
      hit_q  <= 1'b0;
    end else if (ctrl_i.cmp_en) begin
      ins_q  <= ins_d;
      near_q <= near_d;
      hit_q  <= hit_d;
    end
  end

  // On an insert, cells after the insert point move one place right and the
  // first of them takes the new record.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift_en && ins_q) begin
      if (left_ins_i) begin
        key_q     <= left_key_i;
        payload_q <= left_payload_i;
      end else begin
        key_q     <= ctrl_i.key;
        payload_q <= ctrl_i.payload;
      end
    end
  end

  assign key_o     = key_q;
  assign payload_o = payload_q;
  assign ins_o     = ins_q;
  assign near_o    = near_q;
  assign hit_o     = hit_q;

endmodule

[sv/sorted_list_near_duplicate_reject.sv]
// ----------------------------------------------------------------------------
// Sorted line list with near-duplicate rejection
// Keeps line records sorted by key in a row of cells, rejects inserts that
// fall within the match threshold of a stored key, and serves reads by index.
// ----------------------------------------------------------------------------
// Each word goes through three steps from acceptance to its result: it is
// taken in, every cell compares its record against the new key in parallel,
// and the flags are combined, the row shifts and the result is registered.
// A new word is taken once the previous one has left the compare and update
// steps; the result register lets the next word in while a result waits.
// There is no clearing pass after reset.
// ----------------------------------------------------------------------------
module sorted_list_near_duplicate_reject #(
  parameter int unsigned CAPACITY = slndr_pkg::CAPACITY_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [slndr_pkg::THR_W-1:0]   cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  slndr_pkg::in_word_t           in_word_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output slndr_pkg::out_word_t          out_word_o
);

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_APPLY
  } state_e;

  state_e                      state_q;
  slndr_pkg::in_word_t         item_q;
  logic [slndr_pkg::THR_W-1:0] thr_q;
  logic [CNT_W-1:0]            count_q, count_d;
  logic                        out_valid_q;
  slndr_pkg::out_word_t        out_word_q, out_word_d;
  slndr_pkg::cell_ctrl_t       ctrl;
  logic                        apply_go, shift_d;

  logic [slndr_pkg::KEY_W-1:0] cell_key  [CAPACITY];
  logic [slndr_pkg::PAY_W-1:0] cell_pay  [CAPACITY];
  logic [CAPACITY-1:0]         ins_vec, near_vec, hit_vec;

  logic                        near_any, is_full, rd_ok;
  logic [slndr_pkg::KEY_W-1:0] rd_key;
  logic [slndr_pkg::PAY_W-1:0] rd_pay;

  assign in_ready_o = (state_q == S_IDLE);
  assign apply_go   = (state_q == S_APPLY) && (!out_valid_q || out_ready_i);

  // Broadcast to the cells.
  always_comb begin
    ctrl            = '0;
    ctrl.cmp_en     = (state_q == S_CMP);
    ctrl.shift_en   = apply_go && shift_d;
    ctrl.key        = item_q.line_key;
    ctrl.payload    = item_q.line_payload;
    ctrl.thr        = thr_q;
    ctrl.read_index = item_q.read_index;
  end

  // Row of cells; each one hands its record to the right-hand neighbor.
  for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
    if (gi == 0) begin : g_first
      slndr_cell #(.CELL_IDX(gi), .CNT_W(CNT_W)) u_cell (
        .clk_i          (clk_i),
        .rst_ni         (rst_ni),
        .ctrl_i         (ctrl),
        .count_i        (count_q),
        .left_key_i     ('0),
        .left_payload_i ('0),
        .left_ins_i     (1'b0),
        .key_o          (cell_key[gi]),
        .payload_o      (cell_pay[gi]),
        .ins_o          (ins_vec[gi]),
        .near_o         (near_vec[gi]),
        .hit_o          (hit_vec[gi])
      );
    end else begin : g_rest
      slndr_cell #(.CELL_IDX(gi), .CNT_W(CNT_W)) u_cell (
        .clk_i          (clk_i),
        .rst_ni         (rst_ni),
        .ctrl_i         (ctrl),
        .count_i        (count_q),
        .left_key_i     (cell_key[gi-1]),
        .left_payload_i (cell_pay[gi-1]),
        .left_ins_i     (ins_vec[gi-1]),
        .key_o          (cell_key[gi]),
        .payload_o      (cell_pay[gi]),
        .ins_o          (ins_vec[gi]),
        .near_o         (near_vec[gi]),
        .hit_o          (hit_vec[gi])
      );
    end
  end

  // Select the addressed record from the one-hot hit flags.
  always_comb begin
    rd_key = '0;
    rd_pay = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_key = rd_key | (cell_key[i] & {slndr_pkg::KEY_W{hit_vec[i]}});
      rd_pay = rd_pay | (cell_pay[i] & {slndr_pkg::PAY_W{hit_vec[i]}});
    end
  end

  // Decide the outcome of the word in the update cycle.
  always_comb begin
    near_any   = (thr_q != '0) && (|near_vec);
    is_full    = (32'(count_q) >= 32'(CAPACITY));
    rd_ok      = (32'(item_q.read_index) < 32'(count_q));
    count_d    = count_q;
    shift_d    = 1'b0;
    out_word_d = '0;
    case (item_q.action)
      slndr_pkg::ACT_INSERT: begin
        if (near_any) begin
          out_word_d.status = slndr_pkg::ST_NEAR_DUP;
        end else if (is_full) begin
          out_word_d.status = slndr_pkg::ST_FULL;
        end else begin
          out_word_d.status = slndr_pkg::ST_INSERTED;
          shift_d           = 1'b1;
          count_d           = count_q + CNT_W'(1);
        end
      end
      slndr_pkg::ACT_READ: begin
        if (rd_ok) begin
          out_word_d.status            = slndr_pkg::ST_READ_OK;
          out_word_d.entry_key_out     = rd_key;
          out_word_d.entry_payload_out = rd_pay;
        end else begin
          out_word_d.status = slndr_pkg::ST_BAD_INDEX;
        end
      end
      slndr_pkg::ACT_CLEAR: begin
        out_word_d.status = slndr_pkg::ST_CLEARED;
        count_d           = '0;
      end
      default: begin
        out_word_d.status = slndr_pkg::ST_BAD_INDEX;
      end
    endcase
    out_word_d.entry_count_out = slndr_pkg::CNTO_W'(count_d);
  end

  // Sequencer, fill count, threshold and result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      thr_q       <= slndr_pkg::THR_RESET;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        thr_q <= cfg_wdata_i;
      end
      if (apply_go) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= S_CMP;
          end
        end
        S_CMP: begin
          state_q <= S_APPLY;
        end
        S_APPLY: begin
          if (apply_go) begin
            count_q <= count_d;
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // Word and result payload registers.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_word_i;
    end
    if (apply_go) begin
      out_word_q <= out_word_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  // The fill count never passes the list depth.
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) <= 32'(CAPACITY))
    else $error("fill count above capacity");

  // A fresh insert result comes with a count grown by one.
  a_insert_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($rose(out_valid_q) && (out_word_q.status == slndr_pkg::ST_INSERTED))
      |-> (count_q == $past(count_q) + CNT_W'(1)))
    else $error("insert did not grow the list by one");

  // The first two stored records stay in ascending key order.
  a_sorted_head : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(count_q) >= 32'd2) |-> (cell_key[0] <= cell_key[1]))
    else $error("list head out of order");

endmodule
